[hw/rtl/dfr_pkg.sv]
// Shared types, codes and helpers for the descriptor frame reassembler.
// No dependencies.
package dfr_pkg;

   localparam int unsigned MAX_FRAMES = 16;   // largest set size accepted
   localparam int unsigned SLOTS      = 16;   // store depth, one per frame index
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned SIZE_W     = 5;

   // request function codes
   localparam logic FUNC_FEED = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // response status codes
   localparam logic [2:0] STATUS_IGNORED    = 3'd0;
   localparam logic [2:0] STATUS_INCOMPLETE = 3'd1;
   localparam logic [2:0] STATUS_COMPLETE   = 3'd2;
   localparam logic [2:0] STATUS_MALFORMED  = 3'd3;
   localparam logic [2:0] STATUS_READ       = 3'd4;

   typedef struct packed {
      logic [SLOTS-1:0]  mask;
      logic [SIZE_W-1:0] set_size;
      logic [7:0]        seen_schema;
      logic              schema_known;
      logic [31:0]       accepted;
      logic [31:0]       restarts;
   } set_state_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
   } store_wr_type;

   typedef struct packed {
      logic [2:0]        status;
      logic              set_complete;
      logic [63:0]       read_data;
      logic              read_valid;
      logic [SIZE_W-1:0] frames_in_set;
      logic [31:0]       accepted_total;
      logic [31:0]       restart_total;
   } rsp_type;

   // all frames 0..size-1 present; never complete while size is zero
   function automatic logic set_done(input logic [SIZE_W-1:0] size,
                                     input logic [SLOTS-1:0]  mask);
      logic [SLOTS-1:0] want;
      for (int i = 0; i < SLOTS; i++) begin
         want[i] = (SIZE_W'(i) < size);
      end
      return (size != '0) && ((mask & want) == want);
   endfunction

endpackage

[hw/rtl/descriptor_frame_reassembler.sv]
// Top level of the descriptor frame reassembler: set state, frame store, output buffering.
// Depends on dfr_pkg and dfr_decode.
//
//  port group | direction | transfer when         | carries
//  -----------+-----------+-----------------------+-------------------------------------
//  req_       | in        | req_valid & !req_stall | func, frame body, read slot
//  rsp_       | out       | rsp_valid & !rsp_stall | status, read data, set counters
//  csr_       | in        | csr_wr_en              | descriptor page number
//
// One request in, one response out; a new request every cycle while req_stall is low.
// The decode is combinational and its response is registered in the output buffer.
// Reset (synchronous, active high) clears the set state, counters, page and output valids.
// The frame store is not cleared; an entry is only exposed once its mask bit is set.
// A two-entry output buffer (response register plus skid) holds one extra response
// under stalls; req_stall is a flop, high only while the skid entry is occupied.
module descriptor_frame_reassembler import dfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [63:0]       req_frame_body,
   input  logic [SLOT_W-1:0] req_read_slot,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic              rsp_set_complete,
   output logic [63:0]       rsp_read_data,
   output logic              rsp_read_valid,
   output logic [SIZE_W-1:0] rsp_frames_in_set,
   output logic [31:0]       rsp_accepted_total,
   output logic [31:0]       rsp_restart_total,
   // configuration
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   logic [7:0]    page_ff;
   set_state_type state_ff;
   set_state_type state_in;
   store_wr_type  store_wr;
   rsp_type       rsp_new;
   logic [63:0]   store_ff [SLOTS];

   // output buffer
   rsp_type       out_ff;
   rsp_type       out_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       skid_ff;
   rsp_type       skid_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;

   logic          accept;
   logic          out_take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   dfr_decode u_decode (
      .func       (req_func),
      .frame_body (req_frame_body),
      .read_slot  (req_read_slot),
      .page       (page_ff),
      .cur        (state_ff),
      .slot_data  (store_ff[req_read_slot]),
      .nxt        (state_in),
      .store_wr   (store_wr),
      .rsp        (rsp_new)
   );

   // descriptor page register
   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
      end else if (csr_wr_en) begin
         page_ff <= csr_wr_data;
      end
   end

   // set state moves only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // frame store, one write per accepted well-formed frame that matches the page
   always_ff @(posedge clock) begin
      if (accept && store_wr.en) begin
         store_ff[store_wr.idx] <= req_frame_body;
      end
   end

   // response register and skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // no request is taken while the skid entry is full
         if (out_take) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_set_complete   = out_ff.set_complete;
   assign rsp_read_data      = out_ff.read_data;
   assign rsp_read_valid     = out_ff.read_valid;
   assign rsp_frames_in_set  = out_ff.frames_in_set;
   assign rsp_accepted_total = out_ff.accepted_total;
   assign rsp_restart_total  = out_ff.restart_total;

endmodule

[hw/rtl/dfr_decode.sv]
// Per-transfer decision logic: frame checks, set restarts, next state and response.
// Depends on dfr_pkg.
module dfr_decode import dfr_pkg::*; (
   input  logic              func,
   input  logic [63:0]       frame_body,
   input  logic [SLOT_W-1:0] read_slot,
   input  logic [7:0]        page,
   input  set_state_type     cur,
   input  logic [63:0]       slot_data,
   output set_state_type     nxt,
   output store_wr_type      store_wr,
   output rsp_type           rsp
);

   logic              page_hit;
   logic [SLOT_W-1:0] index;
   logic [SIZE_W-1:0] count;
   logic [7:0]        schema;
   logic              malformed;
   logic              feed_ok;
   logic              size_chg;
   logic              schema_chg;
   logic [SLOTS-1:0]  mask_kept;
   logic [SLOTS-1:0]  mask_new;
   logic              known_kept;
   logic              done_new;
   logic              rd_hit;

   assign page_hit  = (frame_body[7:0] == page);
   assign index     = frame_body[15:12];
   assign count     = {1'b0, frame_body[11:8]} + SIZE_W'(1);
   assign schema    = frame_body[31:24];
   assign malformed = (count < SIZE_W'(2)) || ({1'b0, index} >= count)
                      || (count > SIZE_W'(MAX_FRAMES));
   assign feed_ok   = (func == FUNC_FEED) && page_hit && !malformed;

   // size change restarts first; a schema check then sees the cleared flag
   assign size_chg   = (cur.set_size != '0) && (cur.set_size != count);
   assign known_kept = size_chg ? 1'b0 : cur.schema_known;
   assign schema_chg = (index == '0) && known_kept && (schema != cur.seen_schema);
   assign mask_kept  = (size_chg || schema_chg) ? '0 : cur.mask;
   assign mask_new   = mask_kept | (SLOTS'(1) << index);

   assign done_new = set_done(count, mask_new);
   assign rd_hit   = cur.mask[read_slot];

   always_comb begin
      nxt          = cur;
      store_wr.en  = feed_ok;
      store_wr.idx = index;
      if (feed_ok) begin
         nxt.mask         = mask_new;
         nxt.set_size     = count;
         nxt.accepted     = cur.accepted + 32'd1;
         nxt.restarts     = cur.restarts + 32'(size_chg) + 32'(schema_chg);
         nxt.schema_known = (index == '0) ? 1'b1 : known_kept;
         nxt.seen_schema  = (index == '0) ? schema : cur.seen_schema;
      end
   end

   always_comb begin
      rsp.read_data  = '0;
      rsp.read_valid = 1'b0;
      case (func)
         FUNC_READ: begin
            rsp.status     = STATUS_READ;
            rsp.read_valid = rd_hit;
            rsp.read_data  = rd_hit ? slot_data : '0;
         end
         default: begin
            if (!page_hit) begin
               rsp.status = STATUS_IGNORED;
            end else if (malformed) begin
               rsp.status = STATUS_MALFORMED;
            end else if (done_new) begin
               rsp.status = STATUS_COMPLETE;
            end else begin
               rsp.status = STATUS_INCOMPLETE;
            end
         end
      endcase
      rsp.set_complete   = set_done(nxt.set_size, nxt.mask);
      rsp.frames_in_set  = nxt.set_size;
      rsp.accepted_total = nxt.accepted;
      rsp.restart_total  = nxt.restarts;
   end

endmodule
